// File: sv/bloom_filter_membership_macros.svh
// ----------------------------------------------------------------------------
// Bloom filter membership: assertion macros
// Concurrent assertion wrappers, clocked on clk, quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_MEMBERSHIP_MACROS_SVH
`define BLOOM_FILTER_MEMBERSHIP_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge out of reset
`define BFM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// condition must never be seen at a clock edge out of reset
`define BFM_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define BFM_ASSERT(label, prop, msg)
`define BFM_NEVER(label, cond, msg)
`endif

`endif

// File: sv/bfm_pkg.sv
// ----------------------------------------------------------------------------
// Bloom filter membership package
// Sizes, hash constants and codes shared by the filter modules.
// ----------------------------------------------------------------------------
package bfm_pkg;

	localparam int FILTER_BITS = 8192;
	localparam int MAX_HASHES  = 8;

	localparam int HASH_W    = 32;
	localparam int SIZE_W    = 14;
	localparam int NH_W      = 4;
	localparam int DIV_W     = SIZE_W;
	localparam int WORD_W    = 32;
	localparam int BIT_W     = $clog2(WORD_W);
	localparam int FWORDS    = FILTER_BITS / WORD_W;
	localparam int FADDR_W   = $clog2(FWORDS);
	localparam int IDX_W     = $clog2(FILTER_BITS);
	localparam int NSLOT     = MAX_HASHES - 1;
	localparam int SLOT_W    = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
	localparam int KCNT_W    = $clog2(MAX_HASHES + 1);
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES  = 2'd1;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_CHECK = 1'b1;

	localparam logic [HASH_W-1:0] MM_C1    = 32'hcc9e2d51;
	localparam logic [HASH_W-1:0] MM_C2    = 32'h1b873593;
	localparam logic [HASH_W-1:0] MM_ADD   = 32'he6546b64;
	localparam logic [HASH_W-1:0] MM_FMIX1 = 32'h85ebca6b;
	localparam logic [HASH_W-1:0] MM_FMIX2 = 32'hc2b2ae35;

endpackage

// File: sv/bfm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bfm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/bfm_mod.sv
// ----------------------------------------------------------------------------
// Bloom filter modulo unit
// Restoring remainder of a 32-bit hash by the filter size, one bit a cycle.
// ----------------------------------------------------------------------------
module bfm_mod
	import bfm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HASH_W-1:0] dividend,
	input  logic [DIV_W-1:0]  divisor,
	output logic              done,
	output logic [DIV_W-1:0]  remainder
);

	localparam int CNT_W = $clog2(HASH_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [HASH_W-1:0] dvd_q;
	logic [DIV_W-1:0]  dsr_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W:0]    trial;
	logic [DIV_W:0]    diff;

	always_comb begin
		trial = {rem_q, dvd_q[HASH_W-1]};
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(HASH_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
			// remainder stays below the divisor, so one subtract suffices
			rem_q <= (trial >= {1'b0, dsr_q}) ? DIV_W'(diff) : DIV_W'(trial);
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// File: sv/bloom_filter_membership.sv
// Sequence: a byte that neither closes a 4-byte block nor ends the key is taken in ST_IDLE
// alone; one that closes a block goes through the multiply states MIX1 and MIX2, then the
// state RAM update in ST_UPD. At the key end each hash is dominated by the 32-step modulo unit.
// Throughput: one key byte at a time; a result beat is held in an output register.
// Reset: asynchronous, active low; a clearing pass over all FILTER_BITS/32 (256) words
// then zeroes the filter RAM while no beat is taken.
// ----------------------------------------------------------------------------
// Bloom filter membership
// Streams key bytes through Murmur3 and Jenkins hashes, then sets or tests
// the addressed bits of a word-organized filter RAM.
// ----------------------------------------------------------------------------
`include "bloom_filter_membership_macros.svh"

module bloom_filter_membership
	import bfm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] data_byte
	input  logic                 s_tuser,   // [0] command
	input  logic                 s_tlast,   // last
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // [0] found, [7:1] zero
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_wdata
);

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b000000000001,
		ST_MIX1  = 12'b000000000010,
		ST_MIX2  = 12'b000000000100,
		ST_UPD   = 12'b000000001000,
		ST_FRD   = 12'b000000010000,
		ST_FX    = 12'b000000100000,
		ST_FM1   = 12'b000001000000,
		ST_FM2   = 12'b000010000000,
		ST_FDIV  = 12'b000100000000,
		ST_FCHK  = 12'b001000000000,
		ST_DONE  = 12'b010000000000,
		ST_SPARE = 12'b100000000000
	} state_t;

	state_t st_q;

	logic [SIZE_W-1:0] fsize_q;
	logic [NH_W-1:0]   nhash_q;
	logic [DIV_W-1:0]  size_eff;
	logic [KCNT_W-1:0] k_eff;

	logic [HASH_W-1:0] jen_q;
	logic [23:0]       blk_q;
	logic [HASH_W-1:0] len_q;
	logic [HASH_W-1:0] kb_q;
	logic [HASH_W-1:0] mul_a_q;
	logic              cmd_q;
	logic              last_q;
	logic              upd_q;
	logic [SLOT_W:0]   cnt_q;
	logic [KCNT_W-1:0] j_q;
	logic              allset_q;
	logic              out_valid_q;
	logic              found_q;
	logic              clr_q;
	logic [FADDR_W-1:0] clr_cnt_q;
	logic [FADDR_W-1:0] faddr_q;
	logic [BIT_W-1:0]   fbit_q;

	logic [MAX_HASHES-1:0] mm_vld_q;
	logic                  mm_vld_s1;
	logic [SLOT_W-1:0]     mm_addr_s1;
	logic                  mm_rd_s1;

	logic              accept;
	logic [1:0]        pos;
	logic [HASH_W-1:0] jen1, jen2, jen3;
	logic [HASH_W-1:0] blk_full;
	logic [23:0]       blk_next;
	logic [HASH_W-1:0] mul_b;
	logic [HASH_W-1:0] mul_p;
	logic [HASH_W-1:0] mm_rdata_raw;
	logic [HASH_W-1:0] mm_rd;
	logic [HASH_W-1:0] mm_upd;
	logic              mm_we, mm_re;
	logic [SLOT_W-1:0] mm_raddr;
	logic [HASH_W-1:0] jfin1, jfin2, jfin3;
	logic [HASH_W-1:0] fx_d1, fx_d2;
	logic [HASH_W-1:0] fm2_h;
	logic              div_start;
	logic [HASH_W-1:0] div_dividend;
	logic              div_done;
	logic [DIV_W-1:0]  div_rem;
	logic [IDX_W-1:0]  fidx;
	logic              f_we;
	logic [FADDR_W-1:0] f_waddr;
	logic [WORD_W-1:0] f_wdata;
	logic [WORD_W-1:0] f_rdata;
	logic              out_load;
	logic              key_end;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsize_q <= SIZE_W'(8192);
			nhash_q <= NH_W'(3);
		end else if (cfg_we) begin
			if (cfg_index == CFG_FILTER_SIZE) begin
				fsize_q <= cfg_wdata;
			end else if (cfg_index == CFG_NUM_HASHES) begin
				nhash_q <= cfg_wdata[NH_W-1:0];
			end
		end
	end

	always_comb begin
		if (fsize_q == '0) begin
			size_eff = DIV_W'(1);
		end else if (32'(fsize_q) > FILTER_BITS) begin
			size_eff = DIV_W'(FILTER_BITS);
		end else begin
			size_eff = DIV_W'(fsize_q);
		end
		if (nhash_q == '0) begin
			k_eff = KCNT_W'(1);
		end else if (32'(nhash_q) > MAX_HASHES) begin
			k_eff = KCNT_W'(MAX_HASHES);
		end else begin
			k_eff = KCNT_W'(nhash_q);
		end
	end

	// ---------------- byte intake ----------------
	assign s_tready = (st_q == ST_IDLE) && !clr_q;
	assign accept   = s_tvalid && s_tready;
	assign pos      = len_q[1:0];

	always_comb begin
		jen1     = jen_q + {24'h0, s_tdata};
		jen2     = jen1 + (jen1 << 10);
		jen3     = jen2 ^ (jen2 >> 6);
		blk_full = {s_tdata, blk_q};
		if (pos == 2'd3) begin
			blk_next = '0;
		end else begin
			blk_next = blk_q | ({16'h0, s_tdata} << {pos, 3'b000});
		end
	end

	// ---------------- shared multiplier ----------------
	always_comb begin
		case (st_q)
			ST_MIX1: mul_b = MM_C1;
			ST_MIX2: mul_b = MM_C2;
			ST_FM1:  mul_b = MM_FMIX1;
			ST_FM2:  mul_b = MM_FMIX2;
			default: mul_b = '0;
		endcase
		mul_p = mul_a_q * mul_b;
	end

	// ---------------- Murmur state RAM ----------------
	always_comb begin
		mm_re    = 1'b0;
		mm_raddr = '0;
		if (st_q == ST_UPD && cnt_q < (SLOT_W+1)'(NSLOT)) begin
			mm_re    = 1'b1;
			mm_raddr = cnt_q[SLOT_W-1:0];
		end else if (st_q == ST_FRD) begin
			mm_re    = 1'b1;
			mm_raddr = (j_q == '0) ? '0 : SLOT_W'(j_q - 1'b1);
		end
		// an entry never written since key start still holds its seed
		mm_rd  = mm_vld_s1 ? mm_rdata_raw : (HASH_W'(mm_addr_s1) + 1'b1);
		mm_upd = {mm_rd[18:0] ^ kb_q[18:0], mm_rd[31:19] ^ kb_q[31:19]};
		mm_upd = mm_upd + (mm_upd << 2) + MM_ADD;
		mm_we  = (st_q == ST_UPD) && mm_rd_s1;
	end

	bfm_ram #(
		.WIDTH(HASH_W),
		.DEPTH(MAX_HASHES)
	) u_mm_ram (
		.clk   (clk),
		.we    (mm_we),
		.waddr (mm_addr_s1),
		.wdata (mm_upd),
		.re    (mm_re),
		.raddr (mm_raddr),
		.rdata (mm_rdata_raw)
	);

	// ---------------- hash finish ----------------
	always_comb begin
		jfin1 = jen_q + (jen_q << 3);
		jfin2 = jfin1 ^ (jfin1 >> 11);
		jfin3 = jfin2 + (jfin2 << 15);
		fx_d1 = (len_q[1:0] != 2'd0) ? (mm_rd ^ kb_q) : mm_rd;
		fx_d1 = fx_d1 ^ len_q;
		fx_d2 = fx_d1 ^ (fx_d1 >> 16);
		fm2_h = mul_p ^ (mul_p >> 16);
		div_start    = 1'b0;
		div_dividend = fm2_h;
		if (st_q == ST_FX && j_q == KCNT_W'(1)) begin
			div_start    = 1'b1;
			div_dividend = jfin3;
		end else if (st_q == ST_FM2) begin
			div_start = 1'b1;
		end
	end

	bfm_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (size_eff),
		.done      (div_done),
		.remainder (div_rem)
	);

	assign fidx = IDX_W'(div_rem);

	// ---------------- filter RAM ----------------
	always_comb begin
		f_we    = clr_q || (st_q == ST_FCHK && cmd_q == CMD_ADD);
		f_waddr = clr_q ? clr_cnt_q : faddr_q;
		f_wdata = clr_q ? '0 : (f_rdata | (WORD_W'(1) << fbit_q));
	end

	bfm_ram #(
		.WIDTH(WORD_W),
		.DEPTH(FWORDS)
	) u_filter_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.re    (div_done),
		.raddr (fidx[IDX_W-1:BIT_W]),
		.rdata (f_rdata)
	);

	assign out_load = (st_q == ST_DONE) && (cmd_q == CMD_CHECK) &&
		(!out_valid_q || m_tready);
	assign key_end  = (st_q == ST_DONE) && ((cmd_q == CMD_ADD) || out_load);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			jen_q       <= '0;
			blk_q       <= '0;
			len_q       <= '0;
			mm_vld_q    <= '0;
			mm_rd_s1    <= 1'b0;
			cnt_q       <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
			clr_q       <= 1'b1;
			clr_cnt_q   <= '0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == FADDR_W'(FWORDS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			mm_rd_s1 <= mm_re;
			if (mm_we) begin
				mm_vld_q[mm_addr_s1] <= 1'b1;
			end
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						jen_q <= jen3;
						blk_q <= blk_next;
						len_q <= len_q + 1'b1;
						if (pos == 2'd3 || s_tlast) begin
							st_q <= ST_MIX1;
						end
					end
				end
				ST_MIX1: st_q <= ST_MIX2;
				ST_MIX2: begin
					cnt_q <= '0;
					j_q   <= '0;
					st_q  <= upd_q ? ST_UPD : ST_FRD;
				end
				ST_UPD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (SLOT_W+1)'(NSLOT)) begin
						st_q <= last_q ? ST_FRD : ST_IDLE;
					end
				end
				ST_FRD: st_q <= ST_FX;
				ST_FX:  st_q <= (j_q == KCNT_W'(1)) ? ST_FDIV : ST_FM1;
				ST_FM1: st_q <= ST_FM2;
				ST_FM2: st_q <= ST_FDIV;
				ST_FDIV: begin
					if (div_done) begin
						st_q <= ST_FCHK;
					end
				end
				ST_FCHK: begin
					j_q  <= j_q + 1'b1;
					st_q <= (j_q + 1'b1 == k_eff) ? ST_DONE : ST_FRD;
				end
				ST_DONE: begin
					if (key_end) begin
						// restart hash states for the next key
						jen_q    <= '0;
						blk_q    <= '0;
						len_q    <= '0;
						mm_vld_q <= '0;
						st_q     <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= s_tuser;
			last_q  <= s_tlast;
			upd_q   <= (pos == 2'd3);
			mul_a_q <= (pos == 2'd3) ? blk_full : {8'h0, blk_next};
		end else if (st_q == ST_MIX1) begin
			mul_a_q <= {mul_p[16:0], mul_p[31:17]};
		end else if (st_q == ST_FX) begin
			mul_a_q <= fx_d2;
		end else if (st_q == ST_FM1) begin
			mul_a_q <= mul_p ^ (mul_p >> 13);
		end
		if (st_q == ST_MIX2) begin
			kb_q     <= mul_p;
			allset_q <= 1'b1;
		end
		if (mm_re) begin
			mm_addr_s1 <= mm_raddr;
			mm_vld_s1  <= mm_vld_q[mm_raddr];
		end
		if (div_done) begin
			faddr_q <= fidx[IDX_W-1:BIT_W];
			fbit_q  <= fidx[BIT_W-1:0];
		end
		if (st_q == ST_FCHK && !f_rdata[fbit_q]) begin
			allset_q <= 1'b0;
		end
		if (out_load) begin
			found_q <= allset_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'h0, found_q};

	`BFM_ASSERT(a_clear_blocks_input, clr_q |-> !s_tready, "input taken during clear pass")
	`BFM_ASSERT(a_index_in_range, div_done |-> (div_rem < size_eff), "filter index out of range")
	`BFM_NEVER(a_mm_same_entry, mm_we && mm_re && (mm_addr_s1 == mm_raddr),
		"state RAM read and write hit the same entry")
	`BFM_ASSERT(a_result_waits, (out_valid_q && !m_tready && st_q == ST_DONE && cmd_q == CMD_CHECK)
		|=> (st_q == ST_DONE), "result loaded over a pending beat")

endmodule

// File: tb/bloom_filter_membership_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter membership testbench
// Streams add and check keys through the filter under random valid/ready
// gaps, predicts every membership answer with a local model of the hashes
// and the bit store, and compares each result beat with the oldest answer.
// ----------------------------------------------------------------------------
module bloom_filter_membership_tb;
	import bfm_pkg::*;

	localparam int SETTLE_CYCLES = 600;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;   // [7:0] data_byte
	logic                 s_tuser = 1'b0; // [0] command
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [7:0]           m_tdata;        // [0] found, [7:1] zero
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SIZE_W-1:0]    cfg_wdata = '0;

	bloom_filter_membership DUT (.*);

	// local copy of the filter and hash state
	logic        bits_model [FILTER_BITS];
	logic [31:0] mm_state [NSLOT];
	logic [31:0] oat_state;
	logic [31:0] pend_bytes;
	logic [31:0] key_len;
	logic [SIZE_W-1:0] size_reg;
	logic [NH_W-1:0]   hashes_reg;

	logic found_q [$];
	logic [95:0] added_keys [$];
	int          added_lens [$];
	int errors = 0;
	int rx_idle_pct = 0;
	int rx_hold = 0;

	initial forever #10 clk = ~clk;

	initial begin
		#40_000_000;
		$display("bloom_filter_membership_tb NOT OK");
		$finish;
	end

	function automatic logic [31:0] rotl(logic [31:0] x, int r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic logic [31:0] mix_block(logic [31:0] k);
		logic [31:0] t;
		t = k * MM_C1;
		t = rotl(t, 15);
		return t * MM_C2;
	endfunction

	function automatic logic [31:0] mm_final(logic [31:0] h0, logic [31:0] tail,
			logic [31:0] len);
		logic [31:0] h;
		h = h0;
		if (len[1:0] != 2'd0)
			h ^= mix_block(tail);
		h ^= len;
		h ^= h >> 16;
		h = h * MM_FMIX1;
		h ^= h >> 13;
		h = h * MM_FMIX2;
		h ^= h >> 16;
		return h;
	endfunction

	task automatic restart_hashes();
		for (int i = 0; i < NSLOT; i++)
			mm_state[i] = i + 1;
		oat_state = '0;
		pend_bytes = '0;
		key_len = '0;
	endtask

	// advance the model by one accepted key byte
	task automatic filter_step(logic cmd, logic [7:0] b, logic lst);
		logic [31:0] kb, h;
		int sz, k, idx;
		logic all_set;
		all_set = 1'b1;
		oat_state += b;
		oat_state += oat_state << 10;
		oat_state ^= oat_state >> 6;
		if (key_len[1:0] == 2'd3) begin
			kb = mix_block(pend_bytes | (32'(b) << 24));
			for (int i = 0; i < NSLOT; i++) begin
				h = rotl(mm_state[i] ^ kb, 13);
				mm_state[i] = h * 32'd5 + MM_ADD;
			end
			pend_bytes = '0;
		end else begin
			pend_bytes |= 32'(b) << (8 * key_len[1:0]);
		end
		key_len += 1;
		if (!lst)
			return;
		sz = (size_reg == 0) ? 1 : (size_reg > FILTER_BITS ? FILTER_BITS : size_reg);
		k = (hashes_reg == 0) ? 1 : (hashes_reg > MAX_HASHES ? MAX_HASHES : hashes_reg);
		for (int j = 0; j < k; j++) begin
			if (j == 1) begin
				h = oat_state;
				h += h << 3;
				h ^= h >> 11;
				h += h << 15;
			end else begin
				h = mm_final(mm_state[(j == 0) ? 0 : j - 1], pend_bytes, key_len);
			end
			idx = h % sz;
			if (cmd == CMD_ADD)
				bits_model[idx] = 1'b1;
			else if (!bits_model[idx])
				all_set = 1'b0;
		end
		restart_hashes();
		if (cmd == CMD_CHECK)
			found_q.push_back(all_set);
	endtask

	task automatic send_beat(logic cmd, logic [7:0] b, logic lst, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= cmd;
		s_tlast <= lst;
		do @(posedge clk); while (!s_tready);
		filter_step(cmd, b, lst);
	endtask

	// early is the command carried on bytes before the last; 2 means random
	task automatic send_key(logic cmd, int early, logic [95:0] d, int n, int idle_pct);
		logic c;
		for (int i = 0; i < n; i++) begin
			c = (i == n - 1) ? cmd : (early == 2 ? 1'($urandom_range(1)) : 1'(early));
			send_beat(c, d[8*i +: 8], i == n - 1, idle_pct);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (found_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_FILTER_SIZE)
			size_reg = val;
		else if (idx == CFG_NUM_HASHES)
			hashes_reg = val[NH_W-1:0];
	endtask

	task automatic set_filter(int sz, int nh);
		drain();
		write_reg(CFG_FILTER_SIZE, SIZE_W'(sz));
		write_reg(CFG_NUM_HASHES, SIZE_W'(($urandom_range(1023) << NH_W) | nh));
	endtask

	task automatic random_key(output logic [95:0] d, output int n);
		d = {$urandom, $urandom, $urandom};
		n = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
	endtask

	task automatic test_directed();
		logic [95:0] d;
		set_filter(8192, 3);
		send_key(CMD_CHECK, 2, 96'h00, 1, 0);
		send_key(CMD_ADD, 2, 96'h00, 1, 0);
		send_key(CMD_CHECK, 2, 96'h00, 1, 0);
		send_key(CMD_ADD, CMD_CHECK, 96'hff_ff, 2, 0);
		send_key(CMD_CHECK, CMD_ADD, 96'hff_ff, 2, 0);
		send_key(CMD_CHECK, 2, 96'hff_ff, 1, 0);
		d = 96'h0403_0201;
		send_key(CMD_ADD, 2, d, 4, 0);
		send_key(CMD_CHECK, 2, d, 4, 0);
		send_key(CMD_CHECK, 2, 96'h05_0403_0201, 5, 0);
		// zero size acts as one bit, zero hash count as one hash
		set_filter(0, 0);
		send_key(CMD_CHECK, 2, 96'h5a, 1, 0);
		send_key(CMD_ADD, 2, 96'h5a, 1, 0);
		send_key(CMD_CHECK, 2, 96'ha5, 1, 0);
		// oversize saturates to the full store, hash count to the maximum
		set_filter(16383, 15);
		send_key(CMD_ADD, 2, 96'h77, 1, 0);
		send_key(CMD_CHECK, 2, 96'h77, 1, 0);
		send_key(CMD_CHECK, 2, 96'h78, 1, 0);
		// writes to unused indexes change nothing
		drain();
		write_reg(2'd2, SIZE_W'($urandom));
		write_reg(2'd3, SIZE_W'($urandom));
		send_key(CMD_CHECK, 2, 96'h77, 1, 0);
	endtask

	task automatic test_random(int n_bytes, int tx_pct, int rx_pct);
		logic [95:0] d;
		int n, sent, pick;
		rx_idle_pct = rx_pct;
		sent = 0;
		while (sent < n_bytes) begin
			pick = $urandom_range(9);
			if (pick < 5 || added_keys.size() == 0) begin
				random_key(d, n);
				send_key(CMD_ADD, 2, d, n, tx_pct);
				added_keys.push_back(d);
				added_lens.push_back(n);
			end else if (pick < 8) begin
				pick = $urandom_range(added_keys.size() - 1);
				d = added_keys[pick];
				n = added_lens[pick];
				send_key(CMD_CHECK, 2, d, n, tx_pct);
			end else begin
				random_key(d, n);
				send_key(CMD_CHECK, 2, d, n, tx_pct);
			end
			sent += n;
		end
	endtask

	task automatic test_backpressure();
		drain();
		rx_idle_pct = 0;
		rx_hold = 3000;
		for (int i = 0; i < 30; i++)
			send_key(CMD_CHECK, 2, added_keys[i % added_keys.size()],
				added_lens[i % added_lens.size()], 0);
		// pause until every answer is back, then carry on
		drain();
		test_random(60, 0, 0);
	endtask

	always @(posedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (found_q.size() == 0) begin
				$error("unexpected result beat, found=%0d", m_tdata[0]);
				errors++;
			end else begin
				if (m_tdata[0] !== found_q[0]) begin
					$error("found: expected %0d, actual %0d", found_q[0], m_tdata[0]);
					errors++;
				end
				if (m_tdata[7:1] !== 7'd0) begin
					$error("tdata pad: expected 0, actual %0h", m_tdata[7:1]);
					errors++;
				end
				void'(found_q.pop_front());
			end
		end
	end

	initial begin
		for (int i = 0; i < FILTER_BITS; i++)
			bits_model[i] = 1'b0;
		restart_hashes();
		size_reg = SIZE_W'(8192);
		hashes_reg = NH_W'(3);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// let the clearing pass finish before any register write
		repeat (300) @(posedge clk);
		test_directed();
		set_filter(64, 4);
		test_random(250, 34, 63);
		set_filter(1, 8);
		test_random(100, 63, 34);
		set_filter(300, 2);
		test_random(200, 63, 34);
		set_filter(8192, 8);
		test_random(250, 0, 0);
		set_filter($urandom_range(1, 8192), $urandom_range(1, 8));
		test_random(150, 34, 63);
		test_backpressure();
		drain();
		if (errors == 0 && found_q.size() == 0)
			$display("bloom_filter_membership_tb OK");
		else
			$display("bloom_filter_membership_tb NOT OK");
		$finish;
	end

endmodule
